>>> src/bfa_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the exhaustive asymmetric TSP search core.
// No dependencies; imported by brute_force_atsp_solver_core.
package bfa_pkg;

  // Built size and weight width defaults.
  localparam int MAX_VERTICES_DEF = 12;
  localparam int WEIGHT_BITS_DEF  = 16;

  // Widths of the request and result fields.
  localparam int VTX_FIELD_W = 4;
  localparam int COST_W      = 20;

  // Saturation value for the reported cost.
  localparam logic [COST_W-1:0] COST_MAX = '1;

  // Vertex count after reset.
  localparam logic [VTX_FIELD_W-1:0] NUM_VERTICES_RESET = 4'd5;

  // Request operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

endpackage

>>> src/brute_force_atsp_solver_core.sv
`timescale 1ns / 1ps
// Exhaustive ATSP search: a write request yields no result.
// A solve walks the permutation tree depth first, stepping through find (with the
// distance read), evaluate and pop at each tree node, plus a closing step at a leaf,
// then emits n results one per cycle as the output is taken.
// Reset clears the control state and sets num_vertices to 5; the distance memory is
// not cleared, and a solve over entries never written returns undefined values.
module brute_force_atsp_solver_core import bfa_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [VTX_FIELD_W-1:0] cfg_num_vertices,
  // Request channel.
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_operation,
  input  logic [VTX_FIELD_W-1:0] in_row_vertex,
  input  logic [VTX_FIELD_W-1:0] in_col_vertex,
  input  logic [15:0]            in_edge_weight,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VTX_FIELD_W-1:0] out_tour_position,
  output logic [VTX_FIELD_W-1:0] out_tour_vertex,
  output logic [COST_W-1:0]      out_best_cost,
  output logic                   out_last_of_tour
);

  localparam int V_W    = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int N_W    = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int C_W    = WEIGHT_BITS + $clog2(MAX_VERTICES + 1);
  localparam int CMP_W  = (C_W > COST_W) ? C_W : COST_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_EVAL,
    ST_CLOSE,
    ST_OUT
  } state_t;

  state_t                   state_r;
  logic [VTX_FIELD_W-1:0]   num_vertices_r;
  logic [N_W-1:0]           n_r;
  logic [V_W-1:0]           slots_r;
  logic [V_W-1:0]           depth_r;
  logic [N_W-1:0]           cand_r;
  logic [V_W-1:0]           v_r;
  logic [V_W-1:0]           prev_r;
  logic [C_W-1:0]           partial_r;
  logic [C_W-1:0]           min_r;
  logic [MAX_VERTICES-1:0]  used_r;
  logic [V_W-1:0]           pos_r;

  // Search stack, one entry per tour slot, plus the best order found.
  logic [V_W-1:0]           order_stk [MAX_VERTICES];
  logic [V_W-1:0]           prev_stk  [MAX_VERTICES];
  logic [C_W-1:0]           part_stk  [MAX_VERTICES];
  logic [V_W-1:0]           best_order [MAX_VERTICES];

  logic [WEIGHT_BITS-1:0]   dist_mem [DEPTH];
  logic [WEIGHT_BITS-1:0]   rd_data_r;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     wr_en;

  logic                     out_valid_r;
  logic [VTX_FIELD_W-1:0]   out_pos_r;
  logic [VTX_FIELD_W-1:0]   out_vtx_r;
  logic [COST_W-1:0]        out_cost_r;
  logic                     out_last_r;

  logic                     in_fire;
  logic                     found;
  logic [V_W-1:0]           find_v;
  logic [C_W-1:0]           sum_w;
  logic [V_W-1:0]           dd;
  logic [N_W-1:0]           n_clamp;
  logic [CMP_W-1:0]         min_ext;
  logic [COST_W-1:0]        cost_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign out_valid         = out_valid_r;
  assign out_tour_position = out_pos_r;
  assign out_tour_vertex   = out_vtx_r;
  assign out_best_cost     = out_cost_r;
  assign out_last_of_tour  = out_last_r;

  // Lowest unused vertex at or above the current candidate and below n.
  always_comb begin
    found  = 1'b0;
    find_v = '0;
    for (int i = MAX_VERTICES - 1; i >= 1; i--) begin
      if (N_W'(i) >= cand_r && N_W'(i) < n_r && !used_r[i]) begin
        found  = 1'b1;
        find_v = V_W'(i);
      end
    end
  end

  assign sum_w = partial_r + C_W'(rd_data_r);
  assign dd    = depth_r - 1'b1;

  always_comb begin
    if (int'(num_vertices_r) < 2) begin
      n_clamp = N_W'(2);
    end else if (int'(num_vertices_r) > MAX_VERTICES) begin
      n_clamp = N_W'(MAX_VERTICES);
    end else begin
      n_clamp = N_W'(num_vertices_r);
    end
  end

  assign min_ext  = CMP_W'(min_r);
  assign cost_sat = (min_ext > CMP_W'(COST_MAX)) ? COST_MAX : min_ext[COST_W-1:0];

  assign wr_en   = in_fire && (in_operation == OP_WRITE) &&
                   (int'(in_row_vertex) < MAX_VERTICES) &&
                   (int'(in_col_vertex) < MAX_VERTICES);
  assign wr_addr = ADDR_W'(in_row_vertex) * ADDR_W'(MAX_VERTICES) + ADDR_W'(in_col_vertex);

  // The search reads the edge to the next candidate, or the closing edge back to vertex 0.
  always_comb begin
    if (state_r == ST_EVAL) begin
      rd_addr = ADDR_W'(v_r) * ADDR_W'(MAX_VERTICES);
    end else begin
      rd_addr = ADDR_W'(prev_r) * ADDR_W'(MAX_VERTICES) + ADDR_W'(find_v);
    end
  end

  // Writes happen only while idle, and the search reads only after leaving idle,
  // so a search read never meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= WEIGHT_BITS'(in_edge_weight);
    end
    rd_data_r <= dist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      num_vertices_r <= NUM_VERTICES_RESET;
      out_valid_r    <= 1'b0;
      n_r            <= N_W'(2);
      slots_r        <= V_W'(1);
      depth_r        <= '0;
      cand_r         <= '0;
      used_r         <= '0;
      pos_r          <= '0;
      partial_r      <= '0;
      min_r          <= '1;
      prev_r         <= '0;
      v_r            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_vertices_r <= cfg_num_vertices;
      end
      // While emitting, the output state owns the valid flag.
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && in_operation == OP_SOLVE) begin
            n_r       <= n_clamp;
            slots_r   <= V_W'(n_clamp - 1'b1);
            depth_r   <= '0;
            cand_r    <= N_W'(1);
            prev_r    <= '0;
            partial_r <= '0;
            min_r     <= '1;
            used_r    <= '0;
            state_r   <= ST_FIND;
          end
        end
        ST_FIND: begin
          if (found) begin
            v_r     <= find_v;
            state_r <= ST_EVAL;
          end else if (depth_r == '0) begin
            pos_r   <= '0;
            state_r <= ST_OUT;
          end else begin
            // Pop one level and move on to the next sibling.
            used_r[order_stk[dd]] <= 1'b0;
            partial_r             <= part_stk[dd];
            prev_r                <= prev_stk[dd];
            cand_r                <= N_W'(order_stk[dd]) + 1'b1;
            depth_r               <= dd;
          end
        end
        ST_EVAL: begin
          if (sum_w >= min_r) begin
            cand_r  <= N_W'(v_r) + 1'b1;
            state_r <= ST_FIND;
          end else begin
            order_stk[depth_r] <= v_r;
            prev_stk[depth_r]  <= prev_r;
            part_stk[depth_r]  <= partial_r;
            used_r[v_r]        <= 1'b1;
            partial_r          <= sum_w;
            prev_r             <= v_r;
            depth_r            <= depth_r + 1'b1;
            cand_r             <= N_W'(1);
            if (depth_r + 1'b1 == slots_r) begin
              state_r <= ST_CLOSE;
            end else begin
              state_r <= ST_FIND;
            end
          end
        end
        ST_CLOSE: begin
          if (sum_w < min_r) begin
            min_r      <= sum_w;
            best_order <= order_stk;
          end
          // No candidate is left at the leaf, so the next step backtracks.
          cand_r  <= n_r;
          state_r <= ST_FIND;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= VTX_FIELD_W'(pos_r);
            out_vtx_r   <= (pos_r == '0) ? '0 : VTX_FIELD_W'(best_order[pos_r - 1'b1]);
            out_cost_r  <= cost_sat;
            out_last_r  <= (pos_r == slots_r);
            pos_r       <= pos_r + 1'b1;
            if (pos_r == slots_r) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The search depth never passes the number of tour slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_OUT) |-> (depth_r <= slots_r))
    else $error("search depth beyond tour slots");

  // Every level on the stack holds exactly one used vertex.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND) |-> ($countones(used_r) == int'(depth_r)))
    else $error("used vertex set out of step with stack depth");

  // A candidate under evaluation is never already on the path, and never vertex 0.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (!used_r[v_r] && v_r != '0))
    else $error("candidate vertex already in use");

  // The leaf is reached only with a full path.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOSE) |-> (depth_r == slots_r))
    else $error("tour closed with incomplete path");

  // The last result carries the final tour position.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_pos_r == VTX_FIELD_W'(slots_r)))
    else $error("last marker on wrong tour position");

endmodule
